// ===== design/dilp_pkg.sv =====
`default_nettype none

package dilp_pkg;

	// probe frame layout
	localparam int unsigned COOKIE_BYTES = 8;
	localparam int unsigned HEADER_BYTES = 12;
	localparam logic [5:0]  MBOX_PROBE   = 6'h3F;
	localparam logic [3:0]  TYPE_PROBE   = 4'd11;
	localparam logic [15:0] UNASSIGNED   = 16'hFFFF;

	localparam logic [63:0] COOKIE_MASK  = {64{1'b1}} >> (64 - 8 * COOKIE_BYTES);
	localparam logic [7:0]  TX_LENGTH    = 8'(COOKIE_BYTES + HEADER_BYTES);
	localparam logic [15:0] RX_LENGTH    = 16'(COOKIE_BYTES + HEADER_BYTES);
	localparam logic [31:0] TX_WORD2     = 32'h00B0_0000 | 32'(COOKIE_BYTES << 4);

	// configuration register indexes
	localparam int unsigned CFG_AW       = 2;
	localparam logic [CFG_AW-1:0] REG_MIN_ID       = 2'd0;
	localparam logic [CFG_AW-1:0] REG_MAX_ID       = 2'd1;
	localparam logic [CFG_AW-1:0] REG_RETRY_ROUNDS = 2'd2;
	localparam logic [CFG_AW-1:0] REG_COOKIE       = 2'd3;

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_TICK   = 3'd1,
		OP_FRAME  = 3'd2,
		OP_PAUSE  = 3'd3,
		OP_RESUME = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_STARTED     = 4'd0,
		ST_SENT_NEXT   = 4'd1,
		ST_SENT_ROUND  = 4'd2,
		ST_SENT_DONE   = 4'd3,
		ST_NOT_LOOP    = 4'd4,
		ST_WRONG_TYPE  = 4'd5,
		ST_BAD_COOKIE  = 4'd6,
		ST_ESTABLISHED = 4'd7,
		ST_ASSIGNED    = 4'd8,
		ST_NO_ACTION   = 4'd9
	} status_t;

	typedef enum logic [2:0] {
		TMR_LEAVE    = 3'd0,
		TMR_STOP     = 3'd1,
		TMR_REARM_SHORT = 3'd2,
		TMR_REARM_LONG  = 3'd3,
		TMR_REARM_1S    = 3'd4
	} timer_t;

	typedef struct packed {
		logic [63:0] rx_cookie;
		logic [15:0] rx_length;
		logic [31:0] rx_word2;
		logic [31:0] rx_word1;
		logic [31:0] rx_word0;
		logic [2:0]  op;
	} req_t;

	typedef struct packed {
		logic [63:0] cookie;
		logic [15:0] retry_rounds;
		logic [15:0] max_id;
		logic [15:0] min_id;
	} cfg_t;

	typedef struct packed {
		logic        attach_user;
		timer_t      timer_action;
		logic [15:0] assigned_id;
		logic [7:0]  tx_length;
		logic [31:0] tx_word2;
		logic [31:0] tx_word1;
		logic [31:0] tx_word0;
		logic        tx_valid;
		status_t     status;
	} res_t;

endpackage

`default_nettype wire

// ===== design/dilp_cfg_regs.sv =====
`default_nettype none

module dilp_cfg_regs
	import dilp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [63:0]       cfg_wdata,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_ID:       cfg_q.min_id       <= cfg_wdata[15:0];
				REG_MAX_ID:       cfg_q.max_id       <= cfg_wdata[15:0];
				REG_RETRY_ROUNDS: cfg_q.retry_rounds <= cfg_wdata[15:0];
				REG_COOKIE:       cfg_q.cookie       <= cfg_wdata;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/dilp_in_stage.sv =====
`default_nettype none

module dilp_in_stage
	import dilp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire logic advance,
	input  req_t      req_in,
	output logic      valid,
	output req_t      req
);

	logic valid_s1;
	req_t req_s1;

	// valid drops when the request moves on and nothing new arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_s1 <= req_in;
		end
	end

	assign valid = valid_s1;
	assign req   = req_s1;

endmodule

`default_nettype wire

// ===== design/dilp_engine.sv =====
`default_nettype none

module dilp_engine
	import dilp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic fire,
	input  req_t      req,
	input  cfg_t      cfg,
	output res_t      res
);

	logic [15:0] device_id_q, candidate_id_q, rounds_left_q;
	logic        armed_q;
	logic [15:0] device_id_d, candidate_id_d, rounds_left_d;
	logic        armed_d;
	logic        loopback, type_ok, mbox_ok, len_ok, cookie_ok;

	assign loopback  = req.rx_word0[15:0] == req.rx_word0[31:16];
	assign type_ok   = req.rx_word2[23:20] == TYPE_PROBE;
	assign mbox_ok   = req.rx_word1[9:4] == MBOX_PROBE;
	assign len_ok    = req.rx_length == RX_LENGTH;
	assign cookie_ok = ((req.rx_cookie ^ cfg.cookie) & COOKIE_MASK) == 64'd0;

	always_comb begin
		device_id_d    = device_id_q;
		candidate_id_d = candidate_id_q;
		rounds_left_d  = rounds_left_q;
		armed_d        = armed_q;
		res            = '0;
		res.status       = ST_NO_ACTION;
		res.timer_action = TMR_LEAVE;

		case (op_t'(req.op))
			OP_START: begin
				candidate_id_d   = cfg.min_id;
				rounds_left_d    = cfg.retry_rounds;
				armed_d          = 1'b1;
				res.timer_action = TMR_REARM_LONG;
				res.status       = ST_STARTED;
			end
			OP_TICK: begin
				if (armed_q) begin
					res.tx_valid  = 1'b1;
					res.tx_word0  = {candidate_id_q, candidate_id_q};
					res.tx_word1  = {22'd0, MBOX_PROBE, 2'b00, rounds_left_q[1:0]};
					res.tx_word2  = TX_WORD2;
					res.tx_length = TX_LENGTH;
					if (candidate_id_q < cfg.max_id) begin
						candidate_id_d   = candidate_id_q + 16'd1;
						res.timer_action = TMR_REARM_SHORT;
						res.status       = ST_SENT_NEXT;
					end else if (rounds_left_q != 16'd0) begin
						candidate_id_d   = cfg.min_id;
						rounds_left_d    = rounds_left_q - 16'd1;
						res.timer_action = TMR_REARM_LONG;
						res.status       = ST_SENT_ROUND;
					end else begin
						armed_d          = 1'b0;
						res.timer_action = TMR_STOP;
						res.status       = ST_SENT_DONE;
					end
				end
			end
			OP_FRAME: begin
				if (device_id_q != UNASSIGNED) begin
					res.status      = ST_ASSIGNED;
					res.attach_user = 1'b1;
				end else if (!loopback) begin
					res.status = ST_NOT_LOOP;
				end else if (!type_ok || !mbox_ok) begin
					res.status = ST_WRONG_TYPE;
				end else if (!len_ok || !cookie_ok) begin
					res.status = ST_BAD_COOKIE;
				end else begin
					armed_d          = 1'b0;
					device_id_d      = req.rx_word0[15:0];
					res.timer_action = TMR_STOP;
					res.attach_user  = 1'b1;
					res.status       = ST_ESTABLISHED;
				end
			end
			OP_PAUSE: begin
				armed_d          = 1'b0;
				res.timer_action = TMR_STOP;
			end
			OP_RESUME: begin
				if (device_id_q == UNASSIGNED) begin
					armed_d          = 1'b1;
					res.timer_action = TMR_REARM_1S;
				end
			end
			default: begin
			end
		endcase

		res.assigned_id = device_id_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q    <= UNASSIGNED;
			candidate_id_q <= 16'd0;
			rounds_left_q  <= 16'd0;
			armed_q        <= 1'b0;
		end else if (fire) begin
			device_id_q    <= device_id_d;
			candidate_id_q <= candidate_id_d;
			rounds_left_q  <= rounds_left_d;
			armed_q        <= armed_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/dilp_out_stage.sv =====
`default_nettype none

module dilp_out_stage
	import dilp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  res_t      res_in,
	input  wire logic take,
	output logic      valid,
	output res_t      res
);

	logic valid_s2;
	res_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_in;
		end
	end

	assign valid = valid_s2;
	assign res   = res_s2;

endmodule

`default_nettype wire

// ===== design/device_id_loopback_probe.sv =====
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser op, s_tdata rx words, length, cookie
// m_       out  m_tvalid/m_tready  m_tuser status, m_tdata probe and timer result
// cfg_     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// one request a cycle sustained while m_tready stays high; a request waits in
// the input register, and its result is loaded into the output register once
// that register has room, which raises m_tvalid
// the engine state updates as the request leaves the input register
// reset clears config, state (device id 0xffff, idle) and both valid bits
// a stalled m_ side holds the output register; the input register keeps
// taking requests until both are full
`default_nettype none

module device_id_loopback_probe
	import dilp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [175:0]      s_tdata,   // rx_word0, rx_word1, rx_word2, rx_length, rx_cookie
	input  wire logic [2:0]        s_tuser,   // op

	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [127:0]           m_tdata,   // tx_valid, tx_word0, tx_word1, tx_word2,
	                                          // tx_length, assigned_id, timer_action,
	                                          // attach_user, zero fill
	output logic [3:0]             m_tuser,   // status

	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [63:0]       cfg_wdata
);

	cfg_t cfg;
	req_t req_in, req;
	res_t res_next, res;
	logic in_valid, in_load, advance, out_free;

	// unpack the incoming request
	assign req_in.op        = s_tuser;
	assign req_in.rx_word0  = s_tdata[31:0];
	assign req_in.rx_word1  = s_tdata[63:32];
	assign req_in.rx_word2  = s_tdata[95:64];
	assign req_in.rx_length = s_tdata[111:96];
	assign req_in.rx_cookie = s_tdata[175:112];

	// output register frees up when empty or being drained this cycle
	assign out_free = !m_tvalid || m_tready;
	assign advance  = in_valid && out_free;
	assign s_tready = !in_valid || out_free;
	assign in_load  = s_tvalid && s_tready;

	dilp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dilp_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (in_load),
		.advance (advance),
		.req_in  (req_in),
		.valid   (in_valid),
		.req     (req)
	);

	// state commits only when the result has somewhere to go
	dilp_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req),
		.cfg    (cfg),
		.res    (res_next)
	);

	dilp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.res_in (res_next),
		.take   (m_tready),
		.valid  (m_tvalid),
		.res    (res)
	);

	// pack the result, lowest field first
	assign m_tuser = res.status;
	assign m_tdata = {3'd0,
	                  res.attach_user,
	                  res.timer_action,
	                  res.assigned_id,
	                  res.tx_length,
	                  res.tx_word2,
	                  res.tx_word1,
	                  res.tx_word0,
	                  res.tx_valid};

endmodule

`default_nettype wire
